// File: hdl/first_fit_heap_allocator_core_defines.svh
// Assertion macros for the first-fit heap allocator core.
// Depends on nothing; included by the top level.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define FFHA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define FFHA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: hdl/ffha_pkg.sv
// Types and constants for the first-fit heap allocator.
// Depends on nothing.
package ffha_pkg;
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_NO_SPACE = 2'd2;
   localparam logic [1:0] ST_UNKNOWN = 2'd3;
   localparam logic [0:0] CSR_HEAP_BASE = 1'b0;
   localparam logic [0:0] CSR_HEAP_BYTES = 1'b1;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [32:0] GRANULE = 33'd16;

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_CHK, S_SPLIT, S_SHIFT_RD, S_SHIFT_WR,
      S_FREE_L, S_FREE_R, S_REM_RD, S_REM_WR, S_DONE
   } state_type;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] payload;
      logic        taken;
   } entry_type;
endpackage

// File: hdl/ffha_if.sv
// Valid/ready channel interfaces for the allocator.
// Depends on nothing.
interface ffha_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] request_size;
   logic [31:0] payload_address;
   modport source (output valid, command, request_size, payload_address, input ready);
   modport sink (input valid, command, request_size, payload_address, output ready);
endinterface

interface ffha_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] result_address;
   logic [10:0] blocks_in_use;
   modport source (output valid, status, result_address, blocks_in_use, input ready);
   modport sink (input valid, status, result_address, blocks_in_use, output ready);
endinterface

interface ffha_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/first_fit_heap_allocator_core.sv
// First-fit heap allocator: block table in one synchronous memory.
// One request at a time; the read-modify-write walk over the table sets the rate.
// Reset (synchronous, high) and any csr write restore a single free block.
// Table memory contents are not cleared; only entries below the count are read.
// Depends on ffha_pkg, ffha_if and the defines header.
`include "first_fit_heap_allocator_core_defines.svh"
module first_fit_heap_allocator_core #(
   parameter int MAX_BLOCKS = 1024,
   parameter int HEADER_BYTES = 16,
   parameter int FOOTER_BYTES = 16
) (
   input logic clock,
   input logic reset,
   ffha_req_if.sink req,
   ffha_rsp_if.source rsp,
   ffha_csr_if.sink csr
);
   localparam int AW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [32:0] OVH = 33'(HEADER_BYTES + FOOTER_BYTES);
   localparam logic [31:0] HDR = 32'(HEADER_BYTES);

   ffha_pkg::entry_type mem [MAX_BLOCKS];
   ffha_pkg::entry_type rd_ff, wr_data;
   logic [AW-1:0] rd_addr, wr_addr;
   logic wr_en;

   ffha_pkg::state_type state_ff, state_in;
   logic [31:0] base_ff, base_in, bytes_ff, bytes_in;
   logic [CW-1:0] cnt_ff, cnt_in, idx_ff, idx_in, ptr_ff, ptr_in;
   logic cmd_ff, cmd_in, init_ff, init_in;
   logic [32:0] need_ff, need_in;
   logic [31:0] addr_ff, addr_in;
   ffha_pkg::entry_type cur_ff, cur_in, hold_ff, hold_in;
   logic [1:0] st_ff, st_in;
   logic [31:0] res_ff, res_in;
   logic vld_ff, vld_in;
   logic [32:0] big;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffha_pkg::S_IDLE;
         base_ff <= '0;
         bytes_ff <= 32'd4194304;
         init_ff <= 1'b1;
         cnt_ff <= CW'(1);
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff <= base_in;
         bytes_ff <= bytes_in;
         init_ff <= init_in;
         cnt_ff <= cnt_in;
         vld_ff <= vld_in;
      end
      idx_ff <= idx_in; ptr_ff <= ptr_in; cmd_ff <= cmd_in; need_ff <= need_in;
      addr_ff <= addr_in; cur_ff <= cur_in; hold_ff <= hold_in;
      st_ff <= st_in; res_ff <= res_in;
   end

   assign req.ready = (state_ff == ffha_pkg::S_IDLE) && !init_ff && !vld_ff && !csr.valid;
   assign csr.ready = (state_ff == ffha_pkg::S_IDLE) && !vld_ff;
   assign rsp.valid = vld_ff;
   assign rsp.status = st_ff;
   assign rsp.result_address = res_ff;
   assign rsp.blocks_in_use = 11'(cnt_ff);

   always_comb begin
      state_in = state_ff; base_in = base_ff; bytes_in = bytes_ff; init_in = init_ff;
      cnt_in = cnt_ff; idx_in = idx_ff; ptr_in = ptr_ff; cmd_in = cmd_ff;
      need_in = need_ff; addr_in = addr_ff; cur_in = cur_ff; hold_in = hold_ff;
      st_in = st_ff; res_in = res_ff; vld_in = vld_ff;
      rd_addr = idx_ff[AW-1:0]; wr_addr = idx_ff[AW-1:0]; wr_en = 1'b0;
      wr_data = cur_ff; big = '0;
      if (vld_ff && rsp.ready) vld_in = 1'b0;
      unique case (state_ff)
         ffha_pkg::S_IDLE: begin
            if (csr.valid && !vld_ff) begin
               if (csr.index == ffha_pkg::CSR_HEAP_BASE) base_in = csr.data;
               else bytes_in = csr.data;
               init_in = 1'b1;
            end else if (init_ff) begin
               wr_addr = '0; wr_en = 1'b1;
               wr_data.start = base_ff;
               wr_data.payload = ({1'b0, bytes_ff} >= OVH) ? 32'({1'b0, bytes_ff} - OVH) : '0;
               wr_data.taken = 1'b0;
               cnt_in = CW'(1); init_in = 1'b0;
            end else if (req.valid && !vld_ff) begin
               cmd_in = req.command;
               need_in = ({1'b0, req.request_size} + 33'd15) & ~33'd15;
               addr_in = req.payload_address;
               idx_in = '0; res_in = ffha_pkg::ALL_ONES;
               if (req.command == ffha_pkg::CMD_ALLOC && req.request_size == '0) begin
                  st_in = ffha_pkg::ST_ZERO; state_in = ffha_pkg::S_DONE;
               end else state_in = ffha_pkg::S_RD;
            end
         end
         ffha_pkg::S_RD: begin
            if (idx_ff >= cnt_ff) begin
               st_in = (cmd_ff == ffha_pkg::CMD_ALLOC) ? ffha_pkg::ST_NO_SPACE
                                                       : ffha_pkg::ST_UNKNOWN;
               state_in = ffha_pkg::S_DONE;
            end else state_in = ffha_pkg::S_CHK;
         end
         ffha_pkg::S_CHK: begin
            cur_in = rd_ff;
            if (cmd_ff == ffha_pkg::CMD_ALLOC) begin
               if (!rd_ff.taken && {1'b0, rd_ff.payload} >= need_ff) begin
                  res_in = rd_ff.start + HDR; st_in = ffha_pkg::ST_OK;
                  cur_in.taken = 1'b1;
                  if ({1'b0, rd_ff.payload} >= need_ff + OVH + ffha_pkg::GRANULE
                      && cnt_ff < CW'(MAX_BLOCKS)) begin
                     cur_in.payload = need_ff[31:0];
                     hold_in.start = 32'({1'b0, rd_ff.start} + OVH + need_ff);
                     hold_in.payload = 32'({1'b0, rd_ff.payload} - need_ff - OVH);
                     hold_in.taken = 1'b0;
                     ptr_in = cnt_ff;
                     state_in = ffha_pkg::S_SPLIT;
                  end else begin
                     wr_en = 1'b1; wr_data = cur_in;
                     state_in = ffha_pkg::S_DONE;
                  end
               end else begin
                  idx_in = idx_ff + CW'(1); state_in = ffha_pkg::S_RD;
               end
            end else if (rd_ff.start + HDR == addr_ff) begin
               st_in = ffha_pkg::ST_OK; cur_in.taken = 1'b0;
               if (idx_ff != '0) begin
                  rd_addr = idx_ff[AW-1:0] - AW'(1); state_in = ffha_pkg::S_FREE_L;
               end else begin
                  ptr_in = '0;
                  rd_addr = idx_ff[AW-1:0] + AW'(1); state_in = ffha_pkg::S_FREE_R;
               end
            end else begin
               idx_in = idx_ff + CW'(1); state_in = ffha_pkg::S_RD;
            end
         end
         ffha_pkg::S_SPLIT: begin
            wr_en = 1'b1; wr_data = cur_ff;
            if (ptr_ff == idx_ff + CW'(1)) state_in = ffha_pkg::S_SHIFT_WR;
            else begin
               rd_addr = ptr_ff[AW-1:0] - AW'(1); state_in = ffha_pkg::S_SHIFT_RD;
            end
         end
         ffha_pkg::S_SHIFT_RD: begin
            wr_addr = ptr_ff[AW-1:0]; wr_en = 1'b1; wr_data = rd_ff;
            ptr_in = ptr_ff - CW'(1);
            if (ptr_ff - CW'(1) == idx_ff + CW'(1)) state_in = ffha_pkg::S_SHIFT_WR;
            else begin
               rd_addr = ptr_ff[AW-1:0] - AW'(2); state_in = ffha_pkg::S_SHIFT_RD;
            end
         end
         ffha_pkg::S_SHIFT_WR: begin
            wr_en = 1'b1; wr_addr = ptr_ff[AW-1:0]; wr_data = hold_ff;
            cnt_in = cnt_ff + CW'(1); state_in = ffha_pkg::S_DONE;
         end
         ffha_pkg::S_FREE_L: begin
            if (!rd_ff.taken) begin
               big = {1'b0, rd_ff.payload} + {1'b0, cur_ff.payload} + OVH;
               cur_in.start = rd_ff.start; cur_in.payload = big[31:0];
               ptr_in = idx_ff; idx_in = idx_ff - CW'(1);
               hold_in = cur_ff;
            end else ptr_in = '0;
            rd_addr = idx_ff[AW-1:0] + AW'(1);
            state_in = ffha_pkg::S_FREE_R;
         end
         ffha_pkg::S_FREE_R: begin
            // ptr_ff nonzero means left merge removed entry ptr_ff
            if (ptr_ff != '0) begin
               if (ptr_ff + CW'(1) < cnt_ff && !rd_ff.taken) begin
                  big = {1'b0, rd_ff.payload} + {1'b0, cur_ff.payload} + OVH;
                  cur_in.payload = big[31:0];
                  hold_in.start = 32'(2);
               end else hold_in.start = 32'(1);
            end else begin
               if (idx_ff + CW'(1) < cnt_ff && !rd_ff.taken) begin
                  big = {1'b0, rd_ff.payload} + {1'b0, cur_ff.payload} + OVH;
                  cur_in.payload = big[31:0];
                  hold_in.start = 32'(1);
               end else hold_in.start = 32'(0);
            end
            state_in = ffha_pkg::S_REM_RD;
         end
         ffha_pkg::S_REM_RD: begin
            wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_data = cur_ff;
            cnt_in = cnt_ff - CW'(hold_ff.start[1:0]);
            ptr_in = idx_ff + CW'(1);
            if (hold_ff.start[1:0] == 2'd0) state_in = ffha_pkg::S_DONE;
            else begin
               rd_addr = idx_ff[AW-1:0] + AW'(1) + AW'(hold_ff.start[1:0]);
               state_in = ffha_pkg::S_REM_WR;
            end
            hold_in.payload = 32'(hold_ff.start[1:0]);
         end
         ffha_pkg::S_REM_WR: begin
            if (ptr_ff >= cnt_ff) state_in = ffha_pkg::S_DONE;
            else begin
               wr_en = 1'b1; wr_addr = ptr_ff[AW-1:0]; wr_data = rd_ff;
               ptr_in = ptr_ff + CW'(1);
               rd_addr = AW'(ptr_ff + CW'(1) + CW'(hold_ff.payload[1:0]));
            end
         end
         ffha_pkg::S_DONE: begin
            vld_in = 1'b1; state_in = ffha_pkg::S_IDLE;
         end
         default: state_in = ffha_pkg::S_IDLE;
      endcase
   end

   `FFHA_ASSERT_IMPL(a_cnt_range, clock, reset, 1'b1,
      cnt_ff >= CW'(1) && cnt_ff <= CW'(MAX_BLOCKS), "entry count out of range")
   `FFHA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp.valid && !rsp.ready,
      rsp.valid && $stable(rsp.status), "response dropped")
   `FFHA_ASSERT_IMPL(a_no_accept_busy, clock, reset, req.valid && req.ready,
      !rsp.valid && state_ff == ffha_pkg::S_IDLE, "request taken while busy")
endmodule

// File: tb/tb_first_fit_heap_allocator_core.sv
// Self-checking testbench for the first-fit heap allocator core.
// Predicts every response from its own copy of the block table and compares.
// Depends on ffha_pkg, ffha_if and first_fit_heap_allocator_core.
module tb_first_fit_heap_allocator_core;
   localparam int TABLE_DEPTH = 1024;
   localparam int HDR = 16;
   localparam int FTR = 16;
   localparam longint OVERHEAD = HDR + FTR;
   localparam int STALL_LIMIT = 40000;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] result_address;
      logic [10:0] blocks_in_use;
   } response_type;

   logic clock;
   logic reset;
   int   error_count;
   int   quiet_cycles;
   int   send_idle_pct;
   int   recv_stall_pct;

   logic [31:0] model_base;
   logic [31:0] model_bytes;
   logic [31:0] tbl_start [TABLE_DEPTH];
   logic [31:0] tbl_payload [TABLE_DEPTH];
   logic        tbl_taken [TABLE_DEPTH];
   int          tbl_count;
   logic [31:0] live_addrs [$];
   response_type pending_responses [$];

   ffha_req_if req_ch ();
   ffha_rsp_if rsp_ch ();
   ffha_csr_if csr_ch ();

   first_fit_heap_allocator_core u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void table_reinit();
      tbl_start[0] = model_base;
      tbl_payload[0] = (model_bytes >= OVERHEAD) ? model_bytes - 32'(OVERHEAD) : 32'd0;
      tbl_taken[0] = 1'b0;
      tbl_count = 1;
      live_addrs.delete();
   endfunction

   function automatic void table_remove(int pos);
      for (int k = pos; k < tbl_count - 1; k++) begin
         tbl_start[k] = tbl_start[k + 1];
         tbl_payload[k] = tbl_payload[k + 1];
         tbl_taken[k] = tbl_taken[k + 1];
      end
      tbl_count--;
   endfunction

   function automatic void merge_with_next(int pos);
      tbl_payload[pos] = 32'(longint'(tbl_payload[pos]) + tbl_payload[pos + 1] + OVERHEAD);
      table_remove(pos + 1);
   endfunction

   function automatic response_type predict_allocation(logic cmd, logic [31:0] size,
                                                       logic [31:0] addr);
      response_type r;
      longint need, have;
      int i;
      r.status = ffha_pkg::ST_OK;
      r.result_address = ffha_pkg::ALL_ONES;
      if (cmd == ffha_pkg::CMD_ALLOC) begin
         if (size == 0) r.status = ffha_pkg::ST_ZERO;
         else begin
            need = (longint'(size) + 15) & ~longint'(15);
            r.status = ffha_pkg::ST_NO_SPACE;
            for (i = 0; i < tbl_count; i++) begin
               have = tbl_payload[i];
               if (tbl_taken[i] || have < need) continue;
               if (have >= need + OVERHEAD + 16 && tbl_count < TABLE_DEPTH) begin
                  for (int k = tbl_count; k > i + 1; k--) begin
                     tbl_start[k] = tbl_start[k - 1];
                     tbl_payload[k] = tbl_payload[k - 1];
                     tbl_taken[k] = tbl_taken[k - 1];
                  end
                  tbl_start[i + 1] = 32'(longint'(tbl_start[i]) + OVERHEAD + need);
                  tbl_payload[i + 1] = 32'(have - need - OVERHEAD);
                  tbl_taken[i + 1] = 1'b0;
                  tbl_payload[i] = 32'(need);
                  tbl_count++;
               end
               tbl_taken[i] = 1'b1;
               r.result_address = tbl_start[i] + 32'(HDR);
               r.status = ffha_pkg::ST_OK;
               live_addrs.push_back(r.result_address);
               break;
            end
         end
      end else begin
         r.status = ffha_pkg::ST_UNKNOWN;
         for (i = 0; i < tbl_count; i++)
            if (tbl_start[i] + 32'(HDR) == addr) break;
         if (i < tbl_count) begin
            if (i > 0 && !tbl_taken[i - 1]) begin
               merge_with_next(i - 1);
               i--;
            end
            if (i + 1 < tbl_count && !tbl_taken[i + 1]) merge_with_next(i);
            tbl_taken[i] = 1'b0;
            r.status = ffha_pkg::ST_OK;
         end
      end
      r.blocks_in_use = 11'(tbl_count);
      return r;
   endfunction

   task automatic send_request(logic cmd, logic [31:0] size, logic [31:0] addr);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.request_size <= size;
      req_ch.payload_address <= addr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_responses.push_back(predict_allocation(cmd, size, addr));
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] value);
      drain();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      if (idx == ffha_pkg::CSR_HEAP_BASE) model_base = value;
      else model_bytes = value;
      table_reinit();
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_free_address();
      int j;
      logic [31:0] a;
      if (live_addrs.size() == 0 || $urandom_range(9) == 0) return $urandom();
      j = $urandom_range(live_addrs.size() - 1);
      a = live_addrs[j];
      if ($urandom_range(3) != 0) live_addrs.delete(j);
      return a;
   endfunction

   task automatic test_directed_cases();
      write_csr(ffha_pkg::CSR_HEAP_BYTES, 32'd1024);
      send_request(ffha_pkg::CMD_ALLOC, 32'd0, 32'd0);
      send_request(ffha_pkg::CMD_ALLOC, 32'd1, 32'hFFFF_FFFF);
      send_request(ffha_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'd0);
      send_request(ffha_pkg::CMD_ALLOC, 32'hFFFF_FFF1, 32'd0);
      send_request(ffha_pkg::CMD_ALLOC, 32'd100, 32'd0);
      send_request(ffha_pkg::CMD_ALLOC, 32'd48, 32'd0);
      send_request(ffha_pkg::CMD_FREE, 32'd0, 32'd5);
      send_request(ffha_pkg::CMD_FREE, 32'hFFFF_FFFF, 32'd16);
      send_request(ffha_pkg::CMD_FREE, 32'd0, 32'd16);
      send_request(ffha_pkg::CMD_ALLOC, 32'd2000, 32'd0);
      send_request(ffha_pkg::CMD_ALLOC, 32'd880, 32'd0);
      send_request(ffha_pkg::CMD_FREE, 32'd0, 32'd160);
      write_csr(ffha_pkg::CSR_HEAP_BYTES, 32'd64);
      send_request(ffha_pkg::CMD_ALLOC, 32'd32, 32'd0);
      send_request(ffha_pkg::CMD_FREE, 32'd0, 32'd16);
      write_csr(ffha_pkg::CSR_HEAP_BYTES, 32'd20);
      send_request(ffha_pkg::CMD_ALLOC, 32'd1, 32'd0);
      write_csr(ffha_pkg::CSR_HEAP_BASE, 32'hFFFF_FFC0);
      write_csr(ffha_pkg::CSR_HEAP_BYTES, 32'd4096);
      send_request(ffha_pkg::CMD_ALLOC, 32'd64, 32'd0);
      send_request(ffha_pkg::CMD_ALLOC, 32'd64, 32'd0);
      send_request(ffha_pkg::CMD_FREE, 32'd0, 32'hFFFF_FFD0);
      write_csr(ffha_pkg::CSR_HEAP_BYTES, 32'hFFFF_FFFF);
      send_request(ffha_pkg::CMD_ALLOC, 32'hFFFF_FFC0, 32'd0);
   endtask

   task automatic test_random_traffic(int count);
      logic [31:0] size;
      for (int n = 0; n < count; n++) begin
         if (n % 30 == 0) begin
            case ($urandom_range(3))
               0: write_csr(ffha_pkg::CSR_HEAP_BASE, $urandom() & 32'hFFFF_FFF0);
               1: write_csr(ffha_pkg::CSR_HEAP_BASE, $urandom());
               2: write_csr(ffha_pkg::CSR_HEAP_BYTES, $urandom_range(8192, 64));
               default: write_csr(ffha_pkg::CSR_HEAP_BYTES, $urandom());
            endcase
         end
         if ($urandom_range(1) == 0) begin
            case ($urandom_range(9))
               0: size = $urandom();
               1: size = 32'd0;
               default: size = $urandom_range(300, 1);
            endcase
            send_request(ffha_pkg::CMD_ALLOC, size, $urandom());
         end else
            send_request(ffha_pkg::CMD_FREE, $urandom(), pick_free_address());
      end
   endtask

   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      response_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_responses.size() == 0) begin
            $error("response with nothing expected");
            error_count++;
         end else begin
            exp_r = pending_responses.pop_front();
            if (rsp_ch.status !== exp_r.status) begin
               $error("status exp %0d got %0d", exp_r.status, rsp_ch.status);
               error_count++;
            end
            if (rsp_ch.result_address !== exp_r.result_address) begin
               $error("result_address exp %h got %h", exp_r.result_address,
                      rsp_ch.result_address);
               error_count++;
            end
            if (rsp_ch.blocks_in_use !== exp_r.blocks_in_use) begin
               $error("blocks_in_use exp %0d got %0d", exp_r.blocks_in_use,
                      rsp_ch.blocks_in_use);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      quiet_cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.command = ffha_pkg::CMD_ALLOC;
      req_ch.request_size = '0;
      req_ch.payload_address = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = ffha_pkg::CSR_HEAP_BASE;
      csr_ch.data = '0;
      model_base = 32'd0;
      model_bytes = 32'd4194304;
      table_reinit();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_request(ffha_pkg::CMD_ALLOC, 32'd16, 32'd0);
      test_directed_cases();
      test_random_traffic(64);
      send_idle_pct = 55;
      test_random_traffic(64);
      send_idle_pct = 0;
      recv_stall_pct = 55;
      test_random_traffic(64);
      send_idle_pct = 30;
      recv_stall_pct = 30;
      test_random_traffic(64);
      drain();
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
